>>> rtl/core/hsv_blob_centroid_tracker_defines.svh
// Assertion macros for the colour-threshold blob tracker.
// No dependencies; the including module must have i_clk and i_rst_n.
`ifndef HSV_BLOB_CENTROID_TRACKER_DEFINES_SVH
`define HSV_BLOB_CENTROID_TRACKER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HBCT_AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hbct check failed");

// next-cycle implication, disabled in reset
`define HBCT_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hbct check failed");

`endif

>>> rtl/core/hbct_pkg.sv
// Shared types and constants of the colour-threshold blob tracker.
// No dependencies.
package hbct_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;

    localparam int CH_W   = 8;   // hue / sat / val
    localparam int POS_W  = 12;  // column, row, centroid
    localparam int CNT_W  = 25;  // pixel count, min area
    localparam int SUM_W  = CNT_W + POS_W;
    localparam int LIM_W  = 15;  // holds the frame limits up to 16384
    localparam int STEP_W = $clog2(POS_W);

    localparam logic [LIM_W-1:0] COL_LIM   = LIM_W'(MAX_COLUMNS);
    localparam logic [LIM_W-1:0] ROW_LIM   = LIM_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // frame-record queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA = 3'd6;

    localparam logic [CH_W-1:0]  RST_HUE_LOW  = 8'd0;
    localparam logic [CH_W-1:0]  RST_HUE_HIGH = 8'd34;
    localparam logic [CH_W-1:0]  RST_SAT_LOW  = 8'd61;
    localparam logic [CH_W-1:0]  RST_SAT_HIGH = 8'd255;
    localparam logic [CH_W-1:0]  RST_VAL_LOW  = 8'd157;
    localparam logic [CH_W-1:0]  RST_VAL_HIGH = 8'd227;
    localparam logic [CNT_W-1:0] RST_MIN_AREA = 25'd1000;

    typedef struct packed {
        logic [CH_W-1:0]  hue_low;
        logic [CH_W-1:0]  hue_high;
        logic [CH_W-1:0]  sat_low;
        logic [CH_W-1:0]  sat_high;
        logic [CH_W-1:0]  val_low;
        logic [CH_W-1:0]  val_high;
        logic [CNT_W-1:0] min_area;
    } t_cfg;

    // per-frame record handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_cols;
        logic [SUM_W-1:0] sum_rows;
    } t_frame;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] cent_x;
        logic [POS_W-1:0] cent_y;
        logic [CNT_W-1:0] area;
        logic             segment_valid;
        logic [POS_W-1:0] prev_x;
        logic [POS_W-1:0] prev_y;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_LOAD
    } t_back_state;

endpackage

>>> rtl/core/hbct_front.sv
// Front: threshold test and per-frame accumulation, one pixel a cycle while i_accept is high.
// Depends on hbct_pkg.
module hbct_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hbct_pkg::t_cfg           i_cfg,
    input  logic                     i_accept,
    input  logic [hbct_pkg::CH_W-1:0]  i_hue,
    input  logic [hbct_pkg::CH_W-1:0]  i_sat,
    input  logic [hbct_pkg::CH_W-1:0]  i_val,
    input  logic [hbct_pkg::POS_W-1:0] i_col,
    input  logic [hbct_pkg::POS_W-1:0] i_row,
    input  logic                     i_frame_end,
    output logic                     o_push,
    output hbct_pkg::t_frame         o_frame
);
    import hbct_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum_c, n_sum_c;
    logic [SUM_W-1:0] r_sum_r, n_sum_r;
    logic             match;
    logic             inc;

    always_comb begin
        match = (i_hue >= i_cfg.hue_low) && (i_hue <= i_cfg.hue_high) &&
                (i_sat >= i_cfg.sat_low) && (i_sat <= i_cfg.sat_high) &&
                (i_val >= i_cfg.val_low) && (i_val <= i_cfg.val_high) &&
                (LIM_W'(i_col) < COL_LIM) && (LIM_W'(i_row) < ROW_LIM);
        // count saturates; sums hold with it
        inc = match && (r_count != COUNT_MAX);
        n_count = r_count + CNT_W'(inc);
        n_sum_c = inc ? (r_sum_c + SUM_W'(i_col)) : r_sum_c;
        n_sum_r = inc ? (r_sum_r + SUM_W'(i_row)) : r_sum_r;

        o_push           = i_accept && i_frame_end;
        o_frame.count    = n_count;
        o_frame.sum_cols = n_sum_c;
        o_frame.sum_rows = n_sum_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum_c <= '0;
            r_sum_r <= '0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_count <= '0;
                r_sum_c <= '0;
                r_sum_r <= '0;
            end else begin
                r_count <= n_count;
                r_sum_c <= n_sum_c;
                r_sum_r <= n_sum_r;
            end
        end
    end

endmodule

>>> rtl/core/hbct_queue.sv
// Short queue of frame records between front and back.
// Depends on hbct_pkg.
module hbct_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hbct_pkg::t_frame i_data,
    input  logic             i_pop,
    output hbct_pkg::t_frame o_data,
    output logic             o_full,
    output logic             o_nonempty
);
    import hbct_pkg::*;

    t_frame          r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wp;
    logic [Q_PW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_full     = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/hbct_back.sv
// Back: area test, two bit-serial centroid divisions, track state, output register.
// Depends on hbct_pkg.
module hbct_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [hbct_pkg::CNT_W-1:0] i_min_area,
    input  logic              i_q_nonempty,
    input  hbct_pkg::t_frame  i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output hbct_pkg::t_result o_result
);
    import hbct_pkg::*;

    t_back_state       r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_found;
    logic [SUM_W-1:0]  r_rem_x;
    logic [SUM_W-1:0]  r_rem_y;
    logic [SUM_W-1:0]  r_dvs;
    logic [POS_W-1:0]  r_qx;
    logic [POS_W-1:0]  r_qy;
    logic [STEP_W-1:0] r_step;
    logic [POS_W-1:0]  r_last_x;
    logic [POS_W-1:0]  r_last_y;
    logic              r_have_last;
    logic              r_out_valid;
    t_result           r_out;
    logic              head_found;
    logic              ge_x;
    logic              ge_y;
    logic              out_free;
    logic              load;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        head_found = (i_q_data.count > i_min_area) && (i_q_data.count != '0);
        ge_x       = (r_rem_x >= r_dvs);
        ge_y       = (r_rem_y >= r_dvs);
        out_free   = !r_out_valid || !i_stall;
        o_q_pop    = 1'b0;
        load       = 1'b0;
        n_state    = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_nonempty) begin
                    o_q_pop = 1'b1;
                    n_state = head_found ? BK_DIV : BK_LOAD;
                end
            end
            BK_DIV: begin
                if (r_step == '0) begin
                    n_state = BK_LOAD;
                end
            end
            BK_LOAD: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_have_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
                if (r_found) begin
                    r_last_x    <= r_qx;
                    r_last_y    <= r_qy;
                    r_have_last <= 1'b1;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: quotient fits POS_W bits since every sum term is below MAX_COLUMNS
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_count <= i_q_data.count;
            r_found <= head_found;
            r_rem_x <= i_q_data.sum_cols;
            r_rem_y <= i_q_data.sum_rows;
            r_dvs   <= {1'b0, i_q_data.count, {(POS_W - 1){1'b0}}};
            r_qx    <= '0;
            r_qy    <= '0;
            r_step  <= STEP_W'(POS_W - 1);
        end else if (r_state == BK_DIV) begin
            r_rem_x <= ge_x ? (r_rem_x - r_dvs) : r_rem_x;
            r_rem_y <= ge_y ? (r_rem_y - r_dvs) : r_rem_y;
            r_qx    <= {r_qx[POS_W-2:0], ge_x};
            r_qy    <= {r_qy[POS_W-2:0], ge_y};
            r_dvs   <= r_dvs >> 1;
            r_step  <= r_step - 1'b1;
        end
        if (load) begin
            r_out.found         <= r_found;
            r_out.cent_x        <= r_found ? r_qx : '0;
            r_out.cent_y        <= r_found ? r_qy : '0;
            r_out.area          <= r_count;
            r_out.segment_valid <= r_found && r_have_last;
            r_out.prev_x        <= r_last_x;
            r_out.prev_y        <= r_last_y;
        end
    end

endmodule

>>> rtl/core/hsv_blob_centroid_tracker.sv
// Colour-threshold blob centroid tracker: takes one HSV pixel word per cycle and,
// on the pixel marked frame_end, returns one result word with the matching area,
// the centroid (when the area exceeds min_area), the previously stored position
// and whether a track segment exists. The front accepts a pixel every cycle; it
// stalls only while the two-entry queue of frame records is full. Each frame
// record occupies the back for a pop, 12 divide steps and a load when an object
// is found, or a pop and a load when not, plus any time the output word waits
// on i_stall; so frames shorter than that time only ride on the queue.
// Depends on hbct_pkg, hbct_front, hbct_queue and hbct_back.
module hsv_blob_centroid_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [hbct_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [hbct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // pixel channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hbct_pkg::CH_W-1:0]           i_hue,
    input  logic [hbct_pkg::CH_W-1:0]           i_sat,
    input  logic [hbct_pkg::CH_W-1:0]           i_val,
    input  logic [hbct_pkg::POS_W-1:0]          i_col,
    input  logic [hbct_pkg::POS_W-1:0]          i_row,
    input  logic                                i_frame_end,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_found,
    output logic [hbct_pkg::POS_W-1:0]          o_cent_x,
    output logic [hbct_pkg::POS_W-1:0]          o_cent_y,
    output logic [hbct_pkg::CNT_W-1:0]          o_area,
    output logic                                o_segment_valid,
    output logic [hbct_pkg::POS_W-1:0]          o_prev_x,
    output logic [hbct_pkg::POS_W-1:0]          o_prev_y
);
    import hbct_pkg::*;

    t_cfg    r_cfg;
    logic    accept;
    logic    push;
    t_frame  push_data;
    t_frame  head;
    logic    q_full;
    logic    q_nonempty;
    logic    q_pop;
    t_result result;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low  <= RST_HUE_LOW;
            r_cfg.hue_high <= RST_HUE_HIGH;
            r_cfg.sat_low  <= RST_SAT_LOW;
            r_cfg.sat_high <= RST_SAT_HIGH;
            r_cfg.val_low  <= RST_VAL_LOW;
            r_cfg.val_high <= RST_VAL_HIGH;
            r_cfg.min_area <= RST_MIN_AREA;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HUE_LOW:  r_cfg.hue_low  <= i_cfg_data[CH_W-1:0];
                CFG_HUE_HIGH: r_cfg.hue_high <= i_cfg_data[CH_W-1:0];
                CFG_SAT_LOW:  r_cfg.sat_low  <= i_cfg_data[CH_W-1:0];
                CFG_SAT_HIGH: r_cfg.sat_high <= i_cfg_data[CH_W-1:0];
                CFG_VAL_LOW:  r_cfg.val_low  <= i_cfg_data[CH_W-1:0];
                CFG_VAL_HIGH: r_cfg.val_high <= i_cfg_data[CH_W-1:0];
                CFG_MIN_AREA: r_cfg.min_area <= i_cfg_data[CNT_W-1:0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // Back-pressure only when the frame-record queue has no room.
    assign o_stall = q_full;
    assign accept  = i_valid && !o_stall;

    hbct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_hue       (i_hue),
        .i_sat       (i_sat),
        .i_val       (i_val),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_frame_end (i_frame_end),
        .o_push      (push),
        .o_frame     (push_data)
    );

    hbct_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_data),
        .i_pop      (q_pop),
        .o_data     (head),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    hbct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_min_area   (r_cfg.min_area),
        .i_q_nonempty (q_nonempty),
        .i_q_data     (head),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (result)
    );

    assign o_found         = result.found;
    assign o_cent_x        = result.cent_x;
    assign o_cent_y        = result.cent_y;
    assign o_area          = result.area;
    assign o_segment_valid = result.segment_valid;
    assign o_prev_x        = result.prev_x;
    assign o_prev_y        = result.prev_y;

endmodule

>>> rtl/core/hbct_checker.sv
// Port-level checks on the result channel of the blob tracker, bound to the top.
// Depends on hbct_pkg and hsv_blob_centroid_tracker_defines.svh.
`include "hsv_blob_centroid_tracker_defines.svh"

module hbct_port_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_stall,
    input logic                         i_found,
    input logic [hbct_pkg::POS_W-1:0]   i_cent_x,
    input logic [hbct_pkg::POS_W-1:0]   i_cent_y,
    input logic [hbct_pkg::CNT_W-1:0]   i_area,
    input logic                         i_seg
);
    import hbct_pkg::*;

    // held word stays offered
    `HBCT_AST_NEXT(a_hold_valid, i_out_valid && i_out_stall, i_out_valid)
    `HBCT_AST_NEXT(a_hold_area, i_out_valid && i_out_stall, $stable(i_area) && $stable(i_found))
    // no object: centroid zeroed and no segment
    `HBCT_AST_SAME(a_miss_zero, i_out_valid && !i_found, ((i_cent_x | i_cent_y) == '0) && !i_seg)
    // an object always has a non-empty area
    `HBCT_AST_SAME(a_found_area, i_out_valid && i_found, i_area != '0)

endmodule

bind hsv_blob_centroid_tracker hbct_port_checker u_hbct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_found     (o_found),
    .i_cent_x    (o_cent_x),
    .i_cent_y    (o_cent_y),
    .i_area      (o_area),
    .i_seg       (o_segment_valid)
);

>>> verif/hbct_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the colour-threshold blob tracker: follows register writes and
// accepted pixel words, predicts one result word per frame and compares it.
// Depends on hbct_pkg.
module hbct_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hbct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hbct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_pix_valid,
    input  logic                            i_pix_stall,
    input  logic [hbct_pkg::CH_W-1:0]       i_hue,
    input  logic [hbct_pkg::CH_W-1:0]       i_sat,
    input  logic [hbct_pkg::CH_W-1:0]       i_val,
    input  logic [hbct_pkg::POS_W-1:0]      i_col,
    input  logic [hbct_pkg::POS_W-1:0]      i_row,
    input  logic                            i_frame_end,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic                            i_found,
    input  logic [hbct_pkg::POS_W-1:0]      i_cent_x,
    input  logic [hbct_pkg::POS_W-1:0]      i_cent_y,
    input  logic [hbct_pkg::CNT_W-1:0]      i_area,
    input  logic                            i_segment_valid,
    input  logic [hbct_pkg::POS_W-1:0]      i_prev_x,
    input  logic [hbct_pkg::POS_W-1:0]      i_prev_y,
    output int                              o_mismatches,
    output int                              o_pending
);
    import hbct_pkg::*;

    t_cfg             limits;
    logic [CNT_W-1:0] frame_count;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic [POS_W-1:0] track_x;
    logic [POS_W-1:0] track_y;
    logic             track_held;
    t_result          due_results[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t ns  hbct mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_HUE_LOW:  limits.hue_low  = data[CH_W-1:0];
            CFG_HUE_HIGH: limits.hue_high = data[CH_W-1:0];
            CFG_SAT_LOW:  limits.sat_low  = data[CH_W-1:0];
            CFG_SAT_HIGH: limits.sat_high = data[CH_W-1:0];
            CFG_VAL_LOW:  limits.val_low  = data[CH_W-1:0];
            CFG_VAL_HIGH: limits.val_high = data[CH_W-1:0];
            CFG_MIN_AREA: limits.min_area = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // accumulate one pixel; on the frame's last pixel, queue the result word
    task automatic take_pixel();
        logic             hit;
        logic [SUM_W-1:0] quot;
        t_result          want;
        hit = i_hue >= limits.hue_low && i_hue <= limits.hue_high &&
              i_sat >= limits.sat_low && i_sat <= limits.sat_high &&
              i_val >= limits.val_low && i_val <= limits.val_high &&
              int'(i_col) < MAX_COLUMNS && int'(i_row) < MAX_ROWS;
        if (hit && frame_count != COUNT_MAX) begin
            frame_count = frame_count + 1'b1;
            col_sum     = col_sum + i_col;
            row_sum     = row_sum + i_row;
        end
        if (i_frame_end) begin
            want       = '0;
            want.area  = frame_count;
            want.found = frame_count > limits.min_area && frame_count != '0;
            if (want.found) begin
                quot        = col_sum / frame_count;
                want.cent_x = quot[POS_W-1:0];
                quot        = row_sum / frame_count;
                want.cent_y = quot[POS_W-1:0];
            end
            want.segment_valid = want.found && track_held;
            want.prev_x        = track_x;
            want.prev_y        = track_y;
            if (want.found) begin
                track_x    = want.cent_x;
                track_y    = want.cent_y;
                track_held = 1'b1;
            end
            due_results.push_back(want);
            frame_count = '0;
            col_sum     = '0;
            row_sum     = '0;
        end
    endtask

    task automatic take_result();
        t_result want;
        if (due_results.size() == 0) begin
            flag_mismatch("result word with no frame awaiting one");
        end else begin
            want = due_results.pop_front();
            check_field("found", i_found, want.found);
            check_field("cent_x", i_cent_x, want.cent_x);
            check_field("cent_y", i_cent_y, want.cent_y);
            check_field("area", i_area, want.area);
            check_field("segment_valid", i_segment_valid, want.segment_valid);
            check_field("prev_x", i_prev_x, want.prev_x);
            check_field("prev_y", i_prev_y, want.prev_y);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limits      = '{RST_HUE_LOW, RST_HUE_HIGH, RST_SAT_LOW, RST_SAT_HIGH,
                            RST_VAL_LOW, RST_VAL_HIGH, RST_MIN_AREA};
            frame_count = '0;
            col_sum     = '0;
            row_sum     = '0;
            track_x     = '0;
            track_y     = '0;
            track_held  = 1'b0;
            due_results.delete();
        end else begin
            if (i_cfg_we)
                write_limit(i_cfg_idx, i_cfg_data);
            if (i_pix_valid && !i_pix_stall)
                take_pixel();
            if (i_res_valid && !i_res_stall)
                take_result();
        end
        o_pending = due_results.size();
    end

endmodule

>>> verif/tb_hsv_blob_centroid_tracker.sv
`timescale 1ns / 100ps
// Testbench top for the colour-threshold blob tracker: makes pixel words, register
// writes and output back-pressure, and prints the verdict.
// Depends on hbct_pkg, hsv_blob_centroid_tracker and hbct_checker.
module tb_hsv_blob_centroid_tracker;
    import hbct_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 300000;
    // back stage: a pop, the divide steps and a load per record, two records may sit in the queue
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PIXELS = 450;
    localparam int NUM_PHASES    = 8;
    // no register lives at this index; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CH_W-1:0]       i_hue = '0;
    logic [CH_W-1:0]       i_sat = '0;
    logic [CH_W-1:0]       i_val = '0;
    logic [POS_W-1:0]      i_col = '0;
    logic [POS_W-1:0]      i_row = '0;
    logic                  i_frame_end = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_found;
    logic [POS_W-1:0]      o_cent_x;
    logic [POS_W-1:0]      o_cent_y;
    logic [CNT_W-1:0]      o_area;
    logic                  o_segment_valid;
    logic [POS_W-1:0]      o_prev_x;
    logic [POS_W-1:0]      o_prev_y;

    int   mismatches;
    int   pending;
    int   cycle_count = 0;

    // sender pacing: words go out in bursts, gaps between them unless disabled
    int   burst_left = 0;
    bit   sender_gaps = 1'b1;
    // receiver pacing: 0 never stalls, 1 short stalls, 2 long stalls
    int   stall_mode = 0;
    int   stall_hold = 0;

    // stimulus-side copy of the limits, used only to aim pixels at the window
    t_cfg aim = '{RST_HUE_LOW, RST_HUE_HIGH, RST_SAT_LOW, RST_SAT_HIGH,
                  RST_VAL_LOW, RST_VAL_HIGH, RST_MIN_AREA};

    always #(HALF_PERIOD) i_clk = ~i_clk;

    hsv_blob_centroid_tracker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_hue           (i_hue),
        .i_sat           (i_sat),
        .i_val           (i_val),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_cent_x        (o_cent_x),
        .o_cent_y        (o_cent_y),
        .o_area          (o_area),
        .o_segment_valid (o_segment_valid),
        .o_prev_x        (o_prev_x),
        .o_prev_y        (o_prev_y)
    );

    hbct_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pix_valid     (i_valid),
        .i_pix_stall     (o_stall),
        .i_hue           (i_hue),
        .i_sat           (i_sat),
        .i_val           (i_val),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_frame_end     (i_frame_end),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_found         (o_found),
        .i_cent_x        (o_cent_x),
        .i_cent_y        (o_cent_y),
        .i_area          (o_area),
        .i_segment_valid (o_segment_valid),
        .i_prev_x        (o_prev_x),
        .i_prev_y        (o_prev_y),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // watchdog: a hung handshake or a lost result word ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[hsv_blob_centroid_tracker] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: i_stall toggles between runs of random length,
    // the run lengths depending on the mode of the current phase.
    always @(negedge i_clk) begin
        if (!i_rst_n || stall_mode == 0) begin
            i_stall <= 1'b0;
        end else if (stall_hold != 0) begin
            stall_hold--;
        end else begin
            i_stall <= ~i_stall;
            if (i_stall)
                stall_hold = (stall_mode == 1) ? $urandom_range(2, 10) : $urandom_range(0, 4);
            else
                stall_hold = (stall_mode == 1) ? $urandom_range(0, 2) : $urandom_range(1, 20);
        end
    end

    // one register write; the enable drops at the following falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_HUE_LOW:  aim.hue_low  = data[CH_W-1:0];
            CFG_HUE_HIGH: aim.hue_high = data[CH_W-1:0];
            CFG_SAT_LOW:  aim.sat_low  = data[CH_W-1:0];
            CFG_SAT_HIGH: aim.sat_high = data[CH_W-1:0];
            CFG_VAL_LOW:  aim.val_low  = data[CH_W-1:0];
            CFG_VAL_HIGH: aim.val_high = data[CH_W-1:0];
            CFG_MIN_AREA: aim.min_area = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Present one pixel word and hold it until accepted. Before a new burst a
    // random gap may be inserted with i_valid low.
    task automatic send_pixel(input logic [CH_W-1:0] h, input logic [CH_W-1:0] s,
                              input logic [CH_W-1:0] v, input logic [POS_W-1:0] c,
                              input logic [POS_W-1:0] r, input logic fe);
        int gap;
        if (burst_left == 0) begin
            gap        = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_hue       <= h;
        i_sat       <= s;
        i_val       <= v;
        i_col       <= c;
        i_row       <= r;
        i_frame_end <= fe;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
    endtask

    // Drop i_valid, wait for every predicted word to come back, then give the
    // back stage time to finish anything still in flight.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] pick_in(input logic [CH_W-1:0] lo,
                                                input logic [CH_W-1:0] hi, input int top);
        if (lo <= hi && int'(hi) <= top)
            return CH_W'($urandom_range(lo, hi));
        return CH_W'($urandom_range(0, top));
    endfunction

    function automatic logic [POS_W-1:0] near_pos(input logic [POS_W-1:0] centre);
        int p;
        p = int'(centre) + int'($urandom_range(0, 30)) - 15;
        if (p < 0)
            p = 0;
        if (p > MAX_COLUMNS - 1)
            p = MAX_COLUMNS - 1;
        return POS_W'(p);
    endfunction

    // Pick a low/high pair: full span, an empty range, or a random window.
    // Junk above bit 7 of the data checks that writes are masked.
    task automatic write_range(input logic [CFG_IDX_W-1:0] lo_idx,
                               input logic [CFG_IDX_W-1:0] hi_idx, input int top);
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] hi;
        case ($urandom_range(0, 7))
            0: begin
                lo = '0;
                hi = CH_W'(top);
            end
            1: begin
                lo = CH_W'($urandom_range(1, top));
                hi = CH_W'($urandom_range(0, lo - 1));
            end
            default: begin
                lo = CH_W'($urandom_range(0, top / 2));
                hi = CH_W'($urandom_range(lo, top));
            end
        endcase
        write_reg(lo_idx, CFG_DATA_W'({$urandom(), lo}));
        write_reg(hi_idx, CFG_DATA_W'({$urandom(), hi}));
    endtask

    task automatic pick_limits();
        logic [CNT_W-1:0] area;
        write_range(CFG_HUE_LOW, CFG_HUE_HIGH, 179);
        write_range(CFG_SAT_LOW, CFG_SAT_HIGH, 255);
        write_range(CFG_VAL_LOW, CFG_VAL_HIGH, 255);
        case ($urandom_range(0, 9))
            0:       area = '0;
            1:       area = COUNT_MAX;
            2:       area = CNT_W'($urandom_range(10, 40));
            default: area = CNT_W'($urandom_range(0, 5));
        endcase
        write_reg(CFG_MIN_AREA, area);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    endtask

    // A frame of random pixels: each aimed inside the colour window with odds 7 in 10,
    // and placed round a random spot with odds 1 in 2, else anywhere.
    task automatic send_random_frame(input int len);
        logic [POS_W-1:0] spot_x;
        logic [POS_W-1:0] spot_y;
        logic [CH_W-1:0]  h;
        logic [CH_W-1:0]  s;
        logic [CH_W-1:0]  v;
        logic [POS_W-1:0] c;
        logic [POS_W-1:0] r;
        int               k;
        spot_x = POS_W'($urandom_range(0, MAX_COLUMNS - 1));
        spot_y = POS_W'($urandom_range(0, MAX_ROWS - 1));
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                h = pick_in(aim.hue_low, aim.hue_high, 179);
                s = pick_in(aim.sat_low, aim.sat_high, 255);
                v = pick_in(aim.val_low, aim.val_high, 255);
            end else begin
                h = CH_W'($urandom_range(0, 179));
                s = CH_W'($urandom());
                v = CH_W'($urandom());
            end
            if ($urandom_range(0, 1)) begin
                c = near_pos(spot_x);
                r = near_pos(spot_y);
            end else begin
                c = POS_W'($urandom());
                r = POS_W'($urandom());
            end
            send_pixel(h, s, v, c, r, k == len - 1);
        end
    endtask

    initial begin
        int phase;
        int sent;
        int len;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset limits (hue 0..34, sat 61..255, val 157..227) ---
        // one matching pixel at the low corners, area 1 is not above 1000
        send_pixel(8'd0, 8'd61, 8'd157, 12'd0, 12'd0, 1'b1);
        // each channel one step outside its window: nothing counts
        send_pixel(8'd35, 8'd61, 8'd157, 12'd5, 12'd5, 1'b0);
        send_pixel(8'd34, 8'd60, 8'd200, 12'd5, 12'd5, 1'b0);
        send_pixel(8'd34, 8'd255, 8'd156, 12'd5, 12'd5, 1'b0);
        send_pixel(8'd20, 8'd100, 8'd228, 12'd5, 12'd5, 1'b1);
        wait_drained();

        // minimum area zero: a single pixel is an object, then a track segment
        write_reg(CFG_MIN_AREA, '0);
        send_pixel(8'd0, 8'd255, 8'd227, 12'd4095, 12'd4095, 1'b1);
        send_pixel(8'd34, 8'd61, 8'd157, 12'd0, 12'd0, 1'b0);
        send_pixel(8'd10, 8'd200, 8'd200, 12'd4095, 12'd4094, 1'b1);
        // zero count with min area zero: no object, stored position kept
        send_pixel(8'd100, 8'd0, 8'd0, 12'd7, 12'd7, 1'b1);
        wait_drained();

        // empty hue window, full sat/val windows, junk in the upper data bits
        write_reg(CFG_HUE_LOW, CFG_DATA_W'({17'h1FFFF, 8'd100}));
        write_reg(CFG_HUE_HIGH, CFG_DATA_W'({17'h0AAAA, 8'd50}));
        write_reg(CFG_SAT_LOW, '0);
        write_reg(CFG_SAT_HIGH, CFG_DATA_W'(8'd255));
        write_reg(CFG_VAL_LOW, CFG_DATA_W'({17'h15555, 8'd0}));
        write_reg(CFG_VAL_HIGH, CFG_DATA_W'(8'd255));
        write_reg(CFG_UNUSED, '1);
        send_pixel(8'd75, 8'd128, 8'd128, 12'd100, 12'd100, 1'b0);
        send_pixel(8'd100, 8'd0, 8'd255, 12'd1, 12'd2, 1'b1);
        wait_drained();

        // widest hue window; three pixels spanning the whole frame
        write_reg(CFG_HUE_LOW, '0);
        write_reg(CFG_HUE_HIGH, CFG_DATA_W'(8'd179));
        send_pixel(8'd179, 8'd0, 8'd0, 12'd4095, 12'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 12'd0, 12'd4095, 1'b0);
        send_pixel(8'd90, 8'd170, 8'd85, 12'd2730, 12'd1365, 1'b1);
        wait_drained();

        // largest minimum area: never an object
        write_reg(CFG_MIN_AREA, CFG_DATA_W'(COUNT_MAX));
        send_pixel(8'd50, 8'd50, 8'd50, 12'd50, 12'd50, 1'b0);
        send_pixel(8'd60, 8'd60, 8'd60, 12'd60, 12'd60, 1'b1);
        wait_drained();

        // count equal to min area is not enough, one more is
        write_reg(CFG_MIN_AREA, CFG_DATA_W'(1));
        send_pixel(8'd1, 8'd2, 8'd3, 12'd1000, 12'd2000, 1'b1);
        send_pixel(8'd1, 8'd2, 8'd3, 12'd1000, 12'd2000, 1'b0);
        send_pixel(8'd178, 8'd254, 8'd254, 12'd1003, 12'd2001, 1'b1);
        wait_drained();

        // --- random phases: new limits, new pacing, short frames mostly ---
        sent = 0;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            pick_limits();
            stall_mode  = phase % 3;
            sender_gaps = (phase % 4 != 1);
            while (sent < (phase + 1) * RANDOM_PIXELS / NUM_PHASES) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
                send_random_frame(len);
                sent += len;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("[hsv_blob_centroid_tracker] OK");
        else
            $display("[hsv_blob_centroid_tracker] ERROR");
        $finish;
    end

endmodule
